[hw/rtl/crpt_pkg.sv]
// Package for the channel RSSI peak tracker: item types, default sizes and
// the raw-RSSI to dBm curve as a constant table. No dependencies.
package crpt_pkg;

  localparam int ChannelCountDflt = 79;
  localparam int WindowDepthDflt  = 10;

  localparam int RssiW = 8;
  localparam int ChanW = 7;

  typedef struct packed {
    logic [ChanW-1:0]        channel;
    logic signed [RssiW-1:0] peak_rssi;
    logic signed [RssiW-1:0] mean_rssi;
  } crpt_in_t;

  typedef struct packed {
    logic signed [RssiW-1:0] signal_dbm;
    logic signed [RssiW-1:0] noise_dbm;
    logic                    channel_ok;
  } crpt_out_t;

  // Curve breakpoints and coefficients
  localparam int FloorRaw   = -48;
  localparam int SteepHi    = -45;
  localparam int MidHi      = 30;
  localparam int CeilRaw    = 35;
  localparam int FloorDbm   = -120;
  localparam int SteepOfs   = 28;
  localparam int MidMul     = 99;
  localparam int MidOfs     = 62;
  localparam int MidDiv     = 110;
  localparam int TopMul     = 60;
  localparam int TopDiv     = 11;

  localparam logic signed [RssiW-1:0] RssiMin = -8'sd128;

  typedef logic signed [RssiW-1:0] dbm_lut_t [256];

  // Evaluated at elaboration only; integer division truncates toward zero.
  function automatic dbm_lut_t build_dbm_lut();
    dbm_lut_t lut;
    int r;
    int v;
    for (int u = 0; u < 256; u++) begin
      r = (u < 128) ? u : u - 256;
      if (r < FloorRaw)     v = FloorDbm;
      else if (r <= SteepHi) v = 6 * (r + SteepOfs);
      else if (r <= MidHi)   v = (MidMul * (r - MidOfs)) / MidDiv;
      else if (r <= CeilRaw) v = (TopMul * (r - CeilRaw)) / TopDiv;
      else                   v = 0;
      lut[u] = RssiW'(v);
    end
    return lut;
  endfunction

  localparam dbm_lut_t DbmLut = build_dbm_lut();

endpackage

[hw/rtl/channel_rssi_peak_tracker.sv]
// Channel RSSI peak tracker: per-channel peak window in a row memory,
// sequential max scan and dBm table lookup. Depends on crpt_pkg.
//
// Each item names a channel and carries a peak and a mean RSSI reading. For
// an in-range channel the block reads that channel's row (WindowDepth raw
// peaks, oldest in the low byte), shifts the new peak in, writes the row
// back, and then walks the WindowDepth entries through one signed compare,
// one entry per cycle, to find the window maximum. The maximum and the mean
// are mapped to dBm through a 256-entry constant table. An in-range item
// passes through accept with memory read, shift and write-back, the compare
// loop, and the result hand-off. An out-of-range channel skips the memory
// and the loop, returns -120 dBm signal and clears channel_ok. in_stall_o is
// high while an item is in work. A finished result sits in an output
// register, so the next item is taken while the previous result is still
// stalled. Rows start at -128 through per-channel valid flops, so no
// clearing pass runs after reset.
module channel_rssi_peak_tracker
  import crpt_pkg::*;
#(
  parameter int ChannelCount = ChannelCountDflt,
  parameter int WindowDepth  = WindowDepthDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  crpt_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output crpt_out_t out_item_o
);

  localparam int RowW  = WindowDepth * RssiW;
  localparam int AddrW = (ChannelCount > 1) ? $clog2(ChannelCount) : 1;
  localparam int CntW  = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRow  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state_q, state_d;

  // Row memory, one window per channel
  logic [RowW-1:0] hist_mem [ChannelCount];
  logic [RowW-1:0] rdata_q;
  logic [ChannelCount-1:0] row_vld_q;

  logic [ChanW-1:0]        chan_q;
  logic signed [RssiW-1:0] peak_q;
  logic signed [RssiW-1:0] mean_q;
  logic                    ok_q;
  logic [RowW-1:0]         window_q, window_d;
  logic signed [RssiW-1:0] max_q, max_d;
  logic [CntW-1:0]         cnt_q, cnt_d;

  logic      out_valid_q, out_valid_d;
  crpt_out_t out_item_q;

  logic            accept;
  logic            in_range;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] row_addr;
  logic [RowW-1:0] old_row;
  logic [RowW-1:0] new_row;
  logic            row_wr;
  logic            deliver;
  logic signed [RssiW-1:0] cand;

  assign accept   = in_valid_i && (state_q == StIdle);
  assign in_range = {1'b0, in_item_i.channel} < (ChanW + 1)'(ChannelCount);
  assign rd_addr  = AddrW'(in_item_i.channel);
  assign row_addr = AddrW'(chan_q);

  // Never-written rows read as all -128
  assign old_row = row_vld_q[row_addr] ? rdata_q : {WindowDepth{RssiMin}};
  assign new_row = (old_row >> RssiW) |
                   (RowW'($unsigned(peak_q)) << (RowW - RssiW));
  assign row_wr  = (state_q == StRow);

  assign cand    = window_q[RssiW-1:0];
  assign deliver = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // Sequencer and shared compare
  always_comb begin
    state_d  = state_q;
    window_d = window_q;
    max_d    = max_q;
    cnt_d    = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          max_d   = RssiMin;
          state_d = in_range ? StRow : StDone;
        end
      end
      StRow: begin
        window_d = new_row;
        cnt_d    = CntW'(WindowDepth - 1);
        state_d  = StScan;
      end
      StScan: begin
        if (cand > max_q) max_d = cand;
        window_d = window_q >> RssiW;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = StDone;
      end
      StDone: begin
        if (deliver) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register: hold while stalled, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (deliver) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (row_wr) row_vld_q[row_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    max_q    <= max_d;
    cnt_q    <= cnt_d;
    if (accept) begin
      chan_q <= in_item_i.channel;
      peak_q <= in_item_i.peak_rssi;
      mean_q <= in_item_i.mean_rssi;
      ok_q   <= in_range;
    end
    if (deliver) begin
      out_item_q.signal_dbm <= DbmLut[$unsigned(max_q)];
      out_item_q.noise_dbm  <= DbmLut[$unsigned(mean_q)];
      out_item_q.channel_ok <= ok_q;
    end
  end

  // Memory: read on accepting an in-range item, write back the shifted row
  always_ff @(posedge clk_i) begin
    if (accept && in_range) rdata_q <= hist_mem[rd_addr];
    if (row_wr) hist_mem[row_addr] <= new_row;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/crpt_checker.sv]
// Port-level checker for the channel RSSI peak tracker, bound to the top
// level. Depends on crpt_pkg.
module crpt_checker
  import crpt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input crpt_out_t out_item_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // One item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // Out-of-range channel reports floor signal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.channel_ok |-> out_item_o.signal_dbm == -8'sd120)
    else $error("bad signal for rejected channel");

  // dBm results stay on the curve's range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.signal_dbm <= 8'sd0 && out_item_o.signal_dbm >= -8'sd120
                 && out_item_o.noise_dbm <= 8'sd0 && out_item_o.noise_dbm >= -8'sd120)
    else $error("dBm out of range");

endmodule

bind channel_rssi_peak_tracker crpt_checker u_crpt_checker (.*);

[bench/tb_channel_rssi_peak_tracker.sv]
`timescale 1ns / 1ps
// Self-checking testbench for channel_rssi_peak_tracker: predicts every result from its own
// per-channel peak windows and dBm curve, with random idling on both channels.
// Depends on crpt_pkg and the channel_rssi_peak_tracker RTL.
module tb_channel_rssi_peak_tracker;
  import crpt_pkg::*;

  localparam int ChannelCount = ChannelCountDflt;
  localparam int WindowDepth  = WindowDepthDflt;
  // Sized from the slowest correct run (~825 items, longest sender gaps, in-range work and
  // receiver stalls) and taken several times over.
  localparam int CycleLimit   = 200000;
  // Drain wait after the last result, to catch strays.
  localparam int DrainCycles  = 3 * (WindowDepth + 3);

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  crpt_in_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  crpt_out_t out_item_o;

  // Shadow of the block's state: one window of raw peaks per channel, oldest at index 0.
  logic signed [RssiW-1:0] peak_rows [ChannelCount][WindowDepth];
  // Results still owed by the block, oldest first.
  crpt_out_t dbm_pending [$];

  int  mismatch_count;
  int  cycle_count;
  bit  idle_on;        // random gaps and stalls allowed
  int  stall_left;

  channel_rssi_peak_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Piecewise-linear radio curve; SV integer division truncates toward zero.
  function automatic logic signed [RssiW-1:0] raw_to_dbm(input int raw);
    int dbm;
    if (raw < FloorRaw) begin
      dbm = FloorDbm;
    end else if (raw <= SteepHi) begin
      dbm = 6 * (raw + SteepOfs);
    end else if (raw <= MidHi) begin
      dbm = (MidMul * (raw - MidOfs)) / MidDiv;
    end else if (raw <= CeilRaw) begin
      dbm = (TopMul * (raw - CeilRaw)) / TopDiv;
    end else begin
      dbm = 0;
    end
    return RssiW'(dbm);
  endfunction

  // For an in-range channel shift the new peak into its window; queue the result the item yields.
  task automatic predict_window_max(input crpt_in_t item);
    crpt_out_t want;
    int        ch;
    int        peak_max;
    ch = item.channel;
    want.noise_dbm  = raw_to_dbm($signed(item.mean_rssi));
    want.signal_dbm = RssiW'(FloorDbm);
    want.channel_ok = 1'b0;
    if (ch < ChannelCount) begin
      for (int i = 0; i < WindowDepth - 1; i++) peak_rows[ch][i] = peak_rows[ch][i + 1];
      peak_rows[ch][WindowDepth - 1] = item.peak_rssi;
      peak_max = peak_rows[ch][0];
      for (int i = 1; i < WindowDepth; i++) begin
        if (peak_rows[ch][i] > peak_max) peak_max = peak_rows[ch][i];
      end
      want.signal_dbm = raw_to_dbm(peak_max);
      want.channel_ok = 1'b1;
    end
    dbm_pending.push_back(want);
  endtask

  function automatic crpt_in_t make_item(input int ch, input int peak, input int mean);
    crpt_in_t item;
    item.channel   = ChanW'(ch);
    item.peak_rssi = RssiW'(peak);
    item.mean_rssi = RssiW'(mean);
    return item;
  endfunction

  // Half the draws span the whole byte, half sit on the interesting part of the curve.
  function automatic int rand_raw();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 255) - 128;
    return $urandom_range(0, 100) - 60;
  endfunction

  // Send one item: optional idle burst first, then hold valid until the block takes it.
  // Entered and left on a rising edge; valid is touched at most once per edge.
  task automatic send_reading(input crpt_in_t item);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_window_max(item);
  endtask

  // Receiver side: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each accepted result against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    crpt_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dbm_pending.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("[%0t] unexpected result sig=%0d noise=%0d ok=%0b", $realtime,
                   $signed(out_item_o.signal_dbm), $signed(out_item_o.noise_dbm),
                   out_item_o.channel_ok);
        end
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = dbm_pending.pop_front();
        if (out_item_o.signal_dbm !== want.signal_dbm ||
            out_item_o.noise_dbm  !== want.noise_dbm  ||
            out_item_o.channel_ok !== want.channel_ok) begin
          if (mismatch_count < 10) begin
            $display("[%0t] mismatch sig exp=%0d got=%0d noise exp=%0d got=%0d ok exp=%0b got=%0b",
                     $realtime, $signed(want.signal_dbm), $signed(out_item_o.signal_dbm),
                     $signed(want.noise_dbm), $signed(out_item_o.noise_dbm),
                     want.channel_ok, out_item_o.channel_ok);
          end
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("channel_rssi_peak_tracker test failed");
      $finish;
    end
  end

  // Fresh rows read as -128: first peak of -128 maps to the floor; a full-scale peak
  // and mean on the last valid channel map to the ceiling.
  task automatic test_fresh_rows();
    send_reading(make_item(0, -128, -128));
    send_reading(make_item(ChannelCount - 1, 127, 127));
  endtask

  // Out-of-range channels: history untouched, signal forced to the floor, noise still mapped.
  task automatic test_out_of_range();
    send_reading(make_item(ChannelCount, 127, 0));
    send_reading(make_item(127, 35, -45));
  endtask

  // Walk both readings across every curve breakpoint on one channel.
  task automatic test_dbm_curve();
    int edges [8] = '{-49, -48, -45, -44, 30, 31, 35, 36};
    foreach (edges[i]) send_reading(make_item(3, edges[i], edges[i]));
  endtask

  // A large peak must dominate for exactly one window and then drop out.
  task automatic test_window_expiry();
    send_reading(make_item(5, 100, -10));
    repeat (WindowDepth) send_reading(make_item(5, -46, -46));
  endtask

  // Mostly runs on one channel (high peak then lower ones, so maxima expire), plus
  // scattered single items, a share of them out of range.
  task automatic test_random_traffic(input int count);
    int sent;
    int ch;
    int len;
    int peak;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 4) begin
        ch   = $urandom_range(0, ChannelCount - 1);
        len  = $urandom_range(WindowDepth - 2, WindowDepth + 4);
        peak = $urandom_range(0, 127);
        send_reading(make_item(ch, peak, rand_raw()));
        for (int i = 1; i < len; i++) begin
          peak = peak - $urandom_range(0, 12);
          if (peak < -128) peak = -128;
          send_reading(make_item(ch, ($urandom_range(0, 3) == 0) ? rand_raw() : peak,
                                 rand_raw()));
        end
        sent += len;
      end else begin
        if ($urandom_range(0, 9) == 0) ch = $urandom_range(ChannelCount, 127);
        else if ($urandom_range(0, 1) == 0) ch = $urandom_range(0, 7);
        else ch = $urandom_range(0, ChannelCount - 1);
        send_reading(make_item(ch, rand_raw(), rand_raw()));
        sent++;
      end
    end
  endtask

  // Closing stretch with no idling on either side: back-to-back items.
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_traffic(count);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    idle_on        = 1'b1;
    foreach (peak_rows[c, i]) peak_rows[c][i] = RssiMin;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fresh_rows();
    test_out_of_range();
    test_dbm_curve();
    test_window_expiry();
    test_random_traffic(700);
    test_back_to_back(100);
    in_valid_i <= 1'b0;

    // Drain: wait for every owed result, then wait DrainCycles for strays.
    while (dbm_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("channel_rssi_peak_tracker test passed");
    end else begin
      $display("channel_rssi_peak_tracker test failed");
    end
    $finish;
  end

endmodule
